// File: rtl/nsvb_pkg.sv
// ----------------------------------------------------------------------------
// nsvb_pkg
// Shared widths, command codes and status codes of the norm-sorted vector
// bucket.
// ----------------------------------------------------------------------------
package nsvb_pkg;

    localparam int ID_W    = 31;
    localparam int ELEM_W  = 16;
    localparam int DIR_W   = 16;
    localparam int NORM_W  = 24;
    localparam int SCORE_W = 32;
    localparam int SUMSQ_W = 40;
    localparam int DOT_W   = 40;
    localparam int NUM_W   = 36;
    localparam int QUO_W   = 17;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_ERASE  = 2'd1,
        CMD_SCORE  = 2'd2,
        CMD_MAX    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_ELEM      = 3'd4
    } status_t;

endpackage

// File: rtl/nsvb_div.sv
// ----------------------------------------------------------------------------
// nsvb_div
// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the quotient fits in QUO_W bits.
// ----------------------------------------------------------------------------
module nsvb_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [nsvb_pkg::NUM_W-1:0]        num,
    input  logic [nsvb_pkg::NORM_W-1:0]       den,
    output logic                              done,
    output logic [nsvb_pkg::QUO_W-1:0]        quo
);

    localparam int REM_W  = nsvb_pkg::NORM_W;
    localparam int Q_W    = nsvb_pkg::QUO_W;
    localparam int STEP_W = $clog2(Q_W + 1);

    logic              run_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [REM_W-1:0]  den_reg;
    logic [Q_W-1:0]    quo_reg;
    logic [REM_W:0]    trial;
    logic              ge;

    assign trial = {rem_reg, quo_reg[Q_W-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= STEP_W'(Q_W);
            end
            else if (run_reg)
            begin
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= REM_W'(num[nsvb_pkg::NUM_W-1:Q_W]);
            quo_reg <= num[Q_W-1:0];
            den_reg <= den;
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? REM_W'(trial - {1'b0, den_reg}) : REM_W'(trial);
            quo_reg <= {quo_reg[Q_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// File: rtl/norm_sorted_vector_bucket_core.sv
// ----------------------------------------------------------------------------
// norm_sorted_vector_bucket_core
// Bucket of vectors kept sorted by norm, largest first, with insert, erase,
// scored query and max-norm query over memory-held entries.
//
//   channel  | handshake               | fields
//   ---------+-------------------------+------------------------------------
//   command  | start / busy            | cmd item_id element_value last_element
//   result   | result_valid (1 cycle)  | result_id score max_norm status
//            |                         | last_result
//
// An element that is not last is acknowledged in the cycle after it is
// taken. Insert takes a bitwise square root, a place search that reads one
// norm at a time and a division for each nonzero element. Score reads one
// direction element at a time, held to the single read port of the direction
// memory. Erase walks the order list until it finds the id. Reset clears
// counts and the order list; memories need no clearing. Results cannot be
// stalled.
// ----------------------------------------------------------------------------
module norm_sorted_vector_bucket_core #(
    parameter int CAPACITY  = 32,
    parameter int DIMENSION = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          cmd,
    input  logic [nsvb_pkg::ID_W-1:0]           item_id,
    input  logic signed [nsvb_pkg::ELEM_W-1:0]  element_value,
    input  logic                                last_element,
    output logic                                result_valid,
    output logic [nsvb_pkg::ID_W-1:0]           result_id,
    output logic signed [nsvb_pkg::SCORE_W-1:0] score,
    output logic [nsvb_pkg::NORM_W-1:0]         max_norm,
    output logic [2:0]                          status,
    output logic                                last_result
);

    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int SW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int DCW    = $clog2(DIMENSION + 1);
    localparam int IW     = (DIMENSION > 1) ? $clog2(DIMENSION) : 1;
    localparam int DEPTH  = CAPACITY * DIMENSION;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SQV_W  = nsvb_pkg::SUMSQ_W + 8;
    localparam int PROD_W = nsvb_pkg::DOT_W + nsvb_pkg::NORM_W;
    localparam int HALF_W = nsvb_pkg::DOT_W / 2;
    localparam int PP_W   = HALF_W + nsvb_pkg::NORM_W;
    localparam int QS_W   = PROD_W + 1 - 27;

    typedef enum logic [4:0] {
        S_IDLE, S_SQRT, S_FIND_RD, S_FIND_CK, S_DIV_RD, S_DIV_ST, S_DIV_WT,
        S_INS_CM, S_ERA_RD, S_ERA_CK, S_MAX_RD, S_MAX_OUT, S_SC_START,
        S_SC_RD, S_SC_MUL, S_SC_ACC, S_SC_NRM, S_SC_P0, S_SC_P1, S_SC_OUT
    } state_t;

    typedef struct packed {
        logic [nsvb_pkg::ID_W-1:0]    id;
        logic [nsvb_pkg::SCORE_W-1:0] sc;
        logic [nsvb_pkg::NORM_W-1:0]  mx;
        nsvb_pkg::status_t            st;
        logic                         lst;
    } res_t;

    function automatic res_t mk_res(input logic [nsvb_pkg::ID_W-1:0] id,
                                    input logic [nsvb_pkg::SCORE_W-1:0] sc,
                                    input logic [nsvb_pkg::NORM_W-1:0] mx,
                                    input nsvb_pkg::status_t st,
                                    input logic lst);
        res_t r;
        r.id  = id;
        r.sc  = sc;
        r.mx  = mx;
        r.st  = st;
        r.lst = lst;
        return r;
    endfunction

    state_t                           state_reg;
    res_t                             res_reg;
    logic                             result_valid_reg;
    logic [SW-1:0]                    order_reg [CAPACITY];
    logic [CW-1:0]                    cnt_reg;
    logic [CW-1:0]                    k_reg;
    logic [CW-1:0]                    pos_reg;
    logic [SW-1:0]                    slot_reg;
    logic [DCW-1:0]                   ecnt_reg;
    logic [DCW-1:0]                   nelem_reg;
    logic [DCW-1:0]                   i_reg;
    logic [nsvb_pkg::SUMSQ_W-1:0]     sumsq_reg;
    logic [SQV_W-1:0]                 sq_v_reg;
    logic [SQV_W-1:0]                 sq_r_reg;
    logic [SQV_W-1:0]                 sq_bit_reg;
    logic [nsvb_pkg::NORM_W-1:0]      norm_reg;
    logic [nsvb_pkg::ID_W-1:0]        id_reg;
    logic                             neg_reg;
    logic signed [31:0]               prod_reg;
    logic signed [nsvb_pkg::DOT_W-1:0] dot_reg;
    logic [PROD_W-1:0]                p_reg;

    logic [nsvb_pkg::NORM_W-1:0]      norm_mem [CAPACITY];
    logic [nsvb_pkg::ID_W-1:0]        id_mem [CAPACITY];
    logic [nsvb_pkg::DIR_W-1:0]       dir_mem [DEPTH];
    logic [nsvb_pkg::ELEM_W-1:0]      vbuf_mem [DIMENSION];
    logic [nsvb_pkg::NORM_W-1:0]      norm_rd;
    logic [nsvb_pkg::ID_W-1:0]        id_rd;
    logic signed [nsvb_pkg::DIR_W-1:0]  dir_rd;
    logic signed [nsvb_pkg::ELEM_W-1:0] vb_rd;

    logic                             accept;
    logic                             is_elem;
    logic                             room;
    logic signed [31:0]               esq;
    logic [nsvb_pkg::SUMSQ_W-1:0]     sumsq_total;
    logic [SW-1:0]                    ent_raddr;
    logic                             ent_we;
    logic [AW-1:0]                    dir_addr;
    logic                             dir_we;
    logic [nsvb_pkg::DIR_W-1:0]       dir_wdata;
    logic [SQV_W-1:0]                 sq_trial;
    logic                             sq_ge;
    logic [SQV_W-1:0]                 sq_r_next;
    logic signed [nsvb_pkg::ELEM_W-1:0] elem_val;
    logic signed [nsvb_pkg::ELEM_W:0] elem_ext;
    logic [nsvb_pkg::ELEM_W:0]        elem_mag;
    logic                             div_zero;
    logic                             div_start;
    logic [nsvb_pkg::NUM_W-1:0]       div_num;
    logic                             div_done;
    logic [nsvb_pkg::QUO_W-1:0]       div_quo;
    logic [nsvb_pkg::DIR_W-1:0]       dir_sat;
    logic [nsvb_pkg::DOT_W-1:0]       dot_mag;
    logic [PP_W-1:0]                  pp_lo;
    logic [PP_W-1:0]                  pp_hi;
    logic [PROD_W:0]                  p_rnd;
    logic [QS_W-1:0]                  qs;
    logic [nsvb_pkg::SCORE_W-1:0]     sc_sat;

    assign busy    = (state_reg != S_IDLE);
    assign accept  = start && (state_reg == S_IDLE);
    assign is_elem = (cmd == nsvb_pkg::CMD_INSERT) || (cmd == nsvb_pkg::CMD_SCORE);
    assign room    = ecnt_reg < DCW'(DIMENSION);
    assign esq     = element_value * element_value;
    assign sumsq_total = sumsq_reg +
                         (room ? nsvb_pkg::SUMSQ_W'($unsigned(esq)) : '0);

    always_comb
    begin
        case (state_reg)
            S_FIND_RD, S_ERA_RD: ent_raddr = order_reg[k_reg[SW-1:0]];
            S_MAX_RD:            ent_raddr = order_reg[0];
            default:             ent_raddr = slot_reg;
        endcase
    end

    assign ent_we   = (state_reg == S_INS_CM);
    assign dir_addr = AW'(AW'(slot_reg) * AW'(DIMENSION) + AW'(i_reg[IW-1:0]));

    assign sq_trial  = sq_r_reg + sq_bit_reg;
    assign sq_ge     = sq_v_reg >= sq_trial;
    assign sq_r_next = sq_ge ? (sq_r_reg >> 1) + sq_bit_reg : (sq_r_reg >> 1);

    assign elem_val  = (i_reg < nelem_reg) ? vb_rd : '0;
    assign elem_ext  = {elem_val[nsvb_pkg::ELEM_W-1], elem_val};
    assign elem_mag  = elem_val[nsvb_pkg::ELEM_W-1] ? (nsvb_pkg::ELEM_W + 1)'(-elem_ext)
                                                    : (nsvb_pkg::ELEM_W + 1)'(elem_ext);
    assign div_zero  = (elem_val == '0) || (norm_reg == '0);
    assign div_start = (state_reg == S_DIV_ST) && !div_zero;
    assign div_num   = nsvb_pkg::NUM_W'({elem_mag, 19'd0}) +
                       nsvb_pkg::NUM_W'(norm_reg >> 1);

    always_comb
    begin
        if (neg_reg)
            dir_sat = (div_quo >= nsvb_pkg::QUO_W'(32768)) ? 16'h8000
                                                           : 16'(-div_quo);
        else
            dir_sat = (div_quo > nsvb_pkg::QUO_W'(32767)) ? 16'h7fff : div_quo[15:0];
    end

    assign dir_we    = ((state_reg == S_DIV_ST) && div_zero) ||
                       ((state_reg == S_DIV_WT) && div_done);
    assign dir_wdata = (state_reg == S_DIV_WT) ? dir_sat : '0;

    assign dot_mag = dot_reg[nsvb_pkg::DOT_W-1] ? nsvb_pkg::DOT_W'(-dot_reg)
                                                : nsvb_pkg::DOT_W'(dot_reg);
    assign pp_lo   = PP_W'(dot_mag[HALF_W-1:0]) * PP_W'(norm_rd);
    assign pp_hi   = PP_W'(dot_mag[nsvb_pkg::DOT_W-1:HALF_W]) * PP_W'(norm_rd);
    assign p_rnd   = {1'b0, p_reg} + ((PROD_W + 1)'(1) << 26);
    assign qs      = p_rnd[PROD_W:27];

    always_comb
    begin
        if (dot_reg[nsvb_pkg::DOT_W-1])
            sc_sat = (qs >= QS_W'(33'h080000000)) ? 32'h80000000 : 32'(-qs);
        else
            sc_sat = (qs > QS_W'(32'h7fffffff)) ? 32'h7fffffff : qs[31:0];
    end

    nsvb_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (norm_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            norm_mem[slot_reg] <= norm_reg;
            id_mem[slot_reg]   <= id_reg;
        end
        norm_rd <= norm_mem[ent_raddr];
        id_rd   <= id_mem[ent_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (dir_we)
            dir_mem[dir_addr] <= dir_wdata;
        dir_rd <= dir_mem[dir_addr];
    end

    always_ff @(posedge clk)
    begin
        if (accept && is_elem && room)
            vbuf_mem[ecnt_reg[IW-1:0]] <= element_value;
        vb_rd <= vbuf_mem[i_reg[IW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
            cnt_reg          <= '0;
            ecnt_reg         <= '0;
            sumsq_reg        <= '0;
            for (int j = 0; j < CAPACITY; j++)
                order_reg[j] <= SW'(j);
        end
        else
        begin
            result_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        id_reg <= item_id;
                        k_reg  <= '0;
                        if (cmd == nsvb_pkg::CMD_ERASE)
                            state_reg <= S_ERA_RD;
                        else if (cmd == nsvb_pkg::CMD_MAX)
                        begin
                            if (cnt_reg == '0)
                            begin
                                result_valid_reg <= 1'b1;
                                res_reg <= mk_res('0, '0, '0, nsvb_pkg::ST_EMPTY, 1'b1);
                            end
                            else
                                state_reg <= S_MAX_RD;
                        end
                        else if (!last_element)
                        begin
                            if (room)
                                ecnt_reg <= ecnt_reg + DCW'(1);
                            sumsq_reg        <= sumsq_total;
                            result_valid_reg <= 1'b1;
                            res_reg <= mk_res(item_id, '0, '0, nsvb_pkg::ST_ELEM, 1'b1);
                        end
                        else
                        begin
                            ecnt_reg  <= '0;
                            sumsq_reg <= '0;
                            nelem_reg <= room ? ecnt_reg + DCW'(1) : ecnt_reg;
                            if (cmd == nsvb_pkg::CMD_INSERT)
                            begin
                                if (cnt_reg >= CW'(CAPACITY))
                                begin
                                    result_valid_reg <= 1'b1;
                                    res_reg <= mk_res(item_id, '0, '0,
                                                      nsvb_pkg::ST_FULL, 1'b1);
                                end
                                else
                                begin
                                    sq_v_reg   <= {sumsq_total, 8'd0};
                                    sq_r_reg   <= '0;
                                    sq_bit_reg <= SQV_W'(1) << (SQV_W - 2);
                                    slot_reg   <= order_reg[cnt_reg[SW-1:0]];
                                    state_reg  <= S_SQRT;
                                end
                            end
                            else if (cnt_reg == '0)
                            begin
                                result_valid_reg <= 1'b1;
                                res_reg <= mk_res('0, '0, '0, nsvb_pkg::ST_EMPTY, 1'b1);
                            end
                            else
                                state_reg <= S_SC_START;
                        end
                    end
                end
                S_SQRT:
                begin
                    if (sq_ge)
                        sq_v_reg <= sq_v_reg - sq_trial;
                    sq_r_reg   <= sq_r_next;
                    sq_bit_reg <= sq_bit_reg >> 2;
                    if (sq_bit_reg[0])
                    begin
                        norm_reg  <= (sq_r_next > SQV_W'(24'hffffff))
                                     ? 24'hffffff : sq_r_next[nsvb_pkg::NORM_W-1:0];
                        state_reg <= S_FIND_RD;
                    end
                end
                S_FIND_RD:
                begin
                    if (k_reg == cnt_reg)
                    begin
                        pos_reg   <= k_reg;
                        i_reg     <= '0;
                        state_reg <= S_DIV_RD;
                    end
                    else
                        state_reg <= S_FIND_CK;
                end
                S_FIND_CK:
                begin
                    if (norm_rd <= norm_reg)
                    begin
                        pos_reg   <= k_reg;
                        i_reg     <= '0;
                        state_reg <= S_DIV_RD;
                    end
                    else
                    begin
                        k_reg     <= k_reg + CW'(1);
                        state_reg <= S_FIND_RD;
                    end
                end
                S_DIV_RD:
                begin
                    if (i_reg == DCW'(DIMENSION))
                        state_reg <= S_INS_CM;
                    else
                        state_reg <= S_DIV_ST;
                end
                S_DIV_ST:
                begin
                    neg_reg <= elem_val[nsvb_pkg::ELEM_W-1];
                    if (div_zero)
                    begin
                        i_reg     <= i_reg + DCW'(1);
                        state_reg <= S_DIV_RD;
                    end
                    else
                        state_reg <= S_DIV_WT;
                end
                S_DIV_WT:
                begin
                    if (div_done)
                    begin
                        i_reg     <= i_reg + DCW'(1);
                        state_reg <= S_DIV_RD;
                    end
                end
                S_INS_CM:
                begin
                    for (int j = 0; j < CAPACITY; j++)
                    begin
                        if (CW'(j) == pos_reg)
                            order_reg[j] <= slot_reg;
                        else if (CW'(j) > pos_reg && CW'(j) <= cnt_reg)
                            order_reg[j] <= order_reg[(j > 0) ? j - 1 : 0];
                    end
                    cnt_reg          <= cnt_reg + CW'(1);
                    result_valid_reg <= 1'b1;
                    res_reg   <= mk_res(id_reg, '0, '0, nsvb_pkg::ST_OK, 1'b1);
                    state_reg <= S_IDLE;
                end
                S_ERA_RD:
                begin
                    if (k_reg == cnt_reg)
                    begin
                        result_valid_reg <= 1'b1;
                        res_reg   <= mk_res(id_reg, '0, '0, nsvb_pkg::ST_NOT_FOUND, 1'b1);
                        state_reg <= S_IDLE;
                    end
                    else
                        state_reg <= S_ERA_CK;
                end
                S_ERA_CK:
                begin
                    if (id_rd == id_reg)
                    begin
                        for (int j = 0; j < CAPACITY; j++)
                        begin
                            if (CW'(j) >= k_reg && (CW + 1)'(j) + (CW + 1)'(1) < (CW + 1)'(cnt_reg))
                                order_reg[j] <= order_reg[(j < CAPACITY - 1) ? j + 1 : j];
                            else if ((CW + 1)'(j) + (CW + 1)'(1) == (CW + 1)'(cnt_reg))
                                order_reg[j] <= order_reg[k_reg[SW-1:0]];
                        end
                        cnt_reg          <= cnt_reg - CW'(1);
                        result_valid_reg <= 1'b1;
                        res_reg   <= mk_res(id_reg, '0, '0, nsvb_pkg::ST_OK, 1'b1);
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        k_reg     <= k_reg + CW'(1);
                        state_reg <= S_ERA_RD;
                    end
                end
                S_MAX_RD:
                begin
                    state_reg <= S_MAX_OUT;
                end
                S_MAX_OUT:
                begin
                    result_valid_reg <= 1'b1;
                    res_reg   <= mk_res(id_rd, '0, norm_rd, nsvb_pkg::ST_OK, 1'b1);
                    state_reg <= S_IDLE;
                end
                S_SC_START:
                begin
                    slot_reg  <= order_reg[k_reg[SW-1:0]];
                    i_reg     <= '0;
                    dot_reg   <= '0;
                    state_reg <= (nelem_reg == '0) ? S_SC_NRM : S_SC_RD;
                end
                S_SC_RD:
                begin
                    state_reg <= S_SC_MUL;
                end
                S_SC_MUL:
                begin
                    prod_reg  <= dir_rd * vb_rd;
                    state_reg <= S_SC_ACC;
                end
                S_SC_ACC:
                begin
                    dot_reg <= dot_reg + nsvb_pkg::DOT_W'(prod_reg);
                    i_reg   <= i_reg + DCW'(1);
                    state_reg <= (i_reg + DCW'(1) == nelem_reg) ? S_SC_NRM : S_SC_RD;
                end
                S_SC_NRM:
                begin
                    state_reg <= S_SC_P0;
                end
                S_SC_P0:
                begin
                    p_reg     <= PROD_W'(pp_lo);
                    state_reg <= S_SC_P1;
                end
                S_SC_P1:
                begin
                    p_reg     <= p_reg + (PROD_W'(pp_hi) << HALF_W);
                    state_reg <= S_SC_OUT;
                end
                S_SC_OUT:
                begin
                    result_valid_reg <= 1'b1;
                    res_reg <= mk_res(id_rd, sc_sat, '0, nsvb_pkg::ST_OK,
                                      k_reg + CW'(1) == cnt_reg);
                    k_reg   <= k_reg + CW'(1);
                    state_reg <= (k_reg + CW'(1) == cnt_reg) ? S_IDLE : S_SC_START;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result_id    = res_reg.id;
    assign score        = res_reg.sc;
    assign max_norm     = res_reg.mx;
    assign status       = res_reg.st;
    assign last_result  = res_reg.lst;

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    assert property (@(posedge clk) disable iff (!rst_n) ecnt_reg <= DCW'(DIMENSION))
        else $error("element count above dimension");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status == nsvb_pkg::ST_EMPTY) |-> (result_id == '0))
        else $error("empty result with nonzero id");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status == nsvb_pkg::ST_FULL) |-> (cnt_reg == CW'(CAPACITY)))
        else $error("full reported below capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !last_element &&
         (cmd == nsvb_pkg::CMD_INSERT || cmd == nsvb_pkg::CMD_SCORE))
        |=> (result_valid && status == nsvb_pkg::ST_ELEM && !busy))
        else $error("element item not acknowledged");

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the norm-sorted vector bucket. Directed tests
// cover the empty bucket, unknown ids, zero and extreme vectors, equal
// norms, duplicate ids, buffer overflow, mixed commands and a full bucket.
// These are followed by random vector traffic. A predictor in the bench keeps
// its own copy of the bucket. Every strobed result is compared field by field
// with the oldest expected result.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CAP   = 32;
    localparam int DIM   = 64;
    localparam int LIMIT = 2000000;

    typedef struct {
        logic [nsvb_pkg::ID_W-1:0]           id;
        logic signed [nsvb_pkg::SCORE_W-1:0] scr;
        logic [nsvb_pkg::NORM_W-1:0]         mx;
        nsvb_pkg::status_t                   st;
        logic                                lst;
    } result_t;

    logic                                clk;
    logic                                rst_n;
    logic                                start;
    logic                                busy;
    nsvb_pkg::cmd_t                      cmd;
    logic [nsvb_pkg::ID_W-1:0]           item_id;
    logic signed [nsvb_pkg::ELEM_W-1:0]  element_value;
    logic                                last_element;
    logic                                result_valid;
    logic [nsvb_pkg::ID_W-1:0]           result_id;
    logic signed [nsvb_pkg::SCORE_W-1:0] score;
    logic [nsvb_pkg::NORM_W-1:0]         max_norm;
    logic [2:0]                          status;
    logic                                last_result;

    norm_sorted_vector_bucket_core #(
        .CAPACITY  (CAP),
        .DIMENSION (DIM)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .item_id       (item_id),
        .element_value (element_value),
        .last_element  (last_element),
        .result_valid  (result_valid),
        .result_id     (result_id),
        .score         (score),
        .max_norm      (max_norm),
        .status        (status),
        .last_result   (last_result)
    );

    // bucket copy
    logic [nsvb_pkg::NORM_W-1:0]        ent_norm [CAP];
    logic [nsvb_pkg::ID_W-1:0]          ent_id   [CAP];
    logic signed [nsvb_pkg::DIR_W-1:0]  ent_dir  [CAP][DIM];
    int                                 ent_count;
    logic signed [nsvb_pkg::ELEM_W-1:0] vec_buf  [DIM];
    int                                 vec_fill;

    result_t pending_results[$];
    int      mismatches;
    int      cycles;
    bit      idle_on;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic report(input string field, input longint exp_v, input longint got_v);
        $display("mismatch %s: expected %0d got %0d at cycle %0d", field, exp_v, got_v, cycles);
        mismatches++;
    endtask

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic signed [nsvb_pkg::DIR_W-1:0] unit_element(
        input longint e, input longint unsigned nrm);
        longint unsigned mag;
        longint unsigned q;
        mag = (e < 0) ? longint'(-e) * 524288 : longint'(e) * 524288;
        q = (mag + nrm / 2) / nrm;
        if (e < 0)
            return (q >= 32768) ? -16'sd32768 : -$signed(q[15:0]);
        return (q > 32767) ? 16'sd32767 : $signed(q[15:0]);
    endfunction

    function automatic logic signed [nsvb_pkg::SCORE_W-1:0] entry_score(input int k);
        longint dot;
        longint prod;
        longint unsigned mag;
        longint unsigned q;
        dot = 0;
        for (int i = 0; i < DIM; i++)
            dot += longint'(ent_dir[k][i]) * longint'(vec_buf[i]);
        prod = dot * longint'({40'd0, ent_norm[k]});
        mag = (prod < 0) ? -prod : prod;
        q = (mag + (64'd1 << 26)) >> 27;
        if (prod < 0)
            return (q >= 64'h8000_0000) ? 32'sh8000_0000 : -$signed(q[31:0]);
        return (q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(q[31:0]);
    endfunction

    task automatic expect_result(input logic [nsvb_pkg::ID_W-1:0] id,
                                 input logic signed [nsvb_pkg::SCORE_W-1:0] s,
                                 input logic [nsvb_pkg::NORM_W-1:0] m,
                                 input nsvb_pkg::status_t st, input logic l);
        result_t r;
        r.id = id; r.scr = s; r.mx = m; r.st = st; r.lst = l;
        pending_results = {pending_results, r};
    endtask

    task automatic store_vector(input logic [nsvb_pkg::ID_W-1:0] id);
        longint unsigned sumsq;
        longint unsigned nrm;
        int pos;
        sumsq = 0;
        for (int i = 0; i < DIM; i++)
            sumsq += longint'(vec_buf[i]) * longint'(vec_buf[i]);
        nrm = floor_sqrt(sumsq << 8);
        if (nrm > 64'hFF_FFFF)
            nrm = 64'hFF_FFFF;
        pos = 0;
        while (pos < ent_count && ent_norm[pos] > nrm)
            pos++;
        for (int k = ent_count; k > pos; k--)
        begin
            ent_norm[k] = ent_norm[k-1];
            ent_id[k] = ent_id[k-1];
            ent_dir[k] = ent_dir[k-1];
        end
        ent_norm[pos] = nrm[nsvb_pkg::NORM_W-1:0];
        ent_id[pos] = id;
        for (int i = 0; i < DIM; i++)
            ent_dir[pos][i] = (nrm == 0) ? '0 : unit_element(vec_buf[i], nrm);
        ent_count++;
    endtask

    task automatic predict_bucket(input nsvb_pkg::cmd_t c,
                                  input logic [nsvb_pkg::ID_W-1:0] id,
                                  input logic signed [nsvb_pkg::ELEM_W-1:0] e,
                                  input logic l);
        int k;
        if (c == nsvb_pkg::CMD_ERASE)
        begin
            k = 0;
            while (k < ent_count && ent_id[k] != id)
                k++;
            if (k == ent_count)
                expect_result(id, 0, 0, nsvb_pkg::ST_NOT_FOUND, 1'b1);
            else
            begin
                for (; k + 1 < ent_count; k++)
                begin
                    ent_norm[k] = ent_norm[k+1];
                    ent_id[k] = ent_id[k+1];
                    ent_dir[k] = ent_dir[k+1];
                end
                ent_count--;
                expect_result(id, 0, 0, nsvb_pkg::ST_OK, 1'b1);
            end
        end
        else if (c == nsvb_pkg::CMD_MAX)
        begin
            if (ent_count == 0)
                expect_result(0, 0, 0, nsvb_pkg::ST_EMPTY, 1'b1);
            else
                expect_result(ent_id[0], 0, ent_norm[0], nsvb_pkg::ST_OK, 1'b1);
        end
        else
        begin
            if (vec_fill < DIM)
            begin
                vec_buf[vec_fill] = e;
                vec_fill++;
            end
            if (!l)
                expect_result(id, 0, 0, nsvb_pkg::ST_ELEM, 1'b1);
            else
            begin
                for (int i = vec_fill; i < DIM; i++)
                    vec_buf[i] = '0;
                vec_fill = 0;
                if (c == nsvb_pkg::CMD_INSERT)
                begin
                    if (ent_count >= CAP)
                        expect_result(id, 0, 0, nsvb_pkg::ST_FULL, 1'b1);
                    else
                    begin
                        store_vector(id);
                        expect_result(id, 0, 0, nsvb_pkg::ST_OK, 1'b1);
                    end
                end
                else if (ent_count == 0)
                    expect_result(0, 0, 0, nsvb_pkg::ST_EMPTY, 1'b1);
                else
                    for (int j = 0; j < ent_count; j++)
                        expect_result(ent_id[j], entry_score(j), 0, nsvb_pkg::ST_OK,
                                      j + 1 == ent_count);
            end
        end
    endtask

    always @(posedge clk)
    begin
        result_t r;
        if (rst_n && result_valid)
        begin
            if (pending_results.size() == 0)
                report("unexpected result id", 0, result_id);
            else
            begin
                r = pending_results.pop_front();
                if (result_id !== r.id)
                    report("result_id", r.id, result_id);
                if (score !== r.scr)
                    report("score", r.scr, score);
                if (max_norm !== r.mx)
                    report("max_norm", r.mx, max_norm);
                if (status !== r.st)
                    report("status", r.st, status);
                if (last_result !== r.lst)
                    report("last_result", r.lst, last_result);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (!idle_on || r < 12)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_item(input nsvb_pkg::cmd_t c, input logic [nsvb_pkg::ID_W-1:0] id,
                             input logic signed [nsvb_pkg::ELEM_W-1:0] e, input logic l);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        cmd <= c;
        item_id <= id;
        element_value <= e;
        last_element <= l;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_bucket(c, id, e, l);
    endtask

    function automatic logic signed [nsvb_pkg::ELEM_W-1:0] rand_elem();
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom());
        return $signed(16'($urandom_range(0, 16384))) - 16'sd8192;
    endfunction

    task automatic send_vector(input nsvb_pkg::cmd_t c, input logic [nsvb_pkg::ID_W-1:0] id,
                               input int len);
        for (int i = 0; i < len; i++)
            send_item((i == len - 1) ? c
                                     : ($urandom_range(0, 1) ? nsvb_pkg::CMD_INSERT
                                                             : nsvb_pkg::CMD_SCORE),
                      id, rand_elem(), i == len - 1);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_empty_bucket();
        send_item(nsvb_pkg::CMD_MAX, 31'h7FFF_FFFF, 16'sh7FFF, 1'b0);
        send_item(nsvb_pkg::CMD_SCORE, 31'd5, 16'sh1000, 1'b1);
        send_item(nsvb_pkg::CMD_ERASE, 31'h5555_5555, 16'sh8000, 1'b1);
    endtask

    task automatic test_extreme_vectors();
        send_item(nsvb_pkg::CMD_INSERT, 31'd0, 16'sd0, 1'b1);
        for (int i = 0; i < 2; i++)
            send_item(nsvb_pkg::CMD_INSERT, 31'h2AAA_AAAA, -16'sd32768, i == 1);
        for (int i = 0; i < DIM + 2; i++)
            send_item(nsvb_pkg::CMD_INSERT, 31'h7FFF_FFFF, 16'sd32767, i == DIM + 1);
        send_item(nsvb_pkg::CMD_MAX, 31'd0, 16'sd0, 1'b0);
        send_vector(nsvb_pkg::CMD_SCORE, 31'd1, 3);
    endtask

    task automatic test_equal_and_duplicate();
        send_item(nsvb_pkg::CMD_INSERT, 31'd77, 16'sh1000, 1'b0);
        send_item(nsvb_pkg::CMD_INSERT, 31'd77, -16'sh0800, 1'b1);
        send_item(nsvb_pkg::CMD_SCORE, 31'd77, -16'sh1000, 1'b0);
        send_item(nsvb_pkg::CMD_INSERT, 31'd77, 16'sh0800, 1'b1);
        send_item(nsvb_pkg::CMD_SCORE, 31'd3, 16'sh1000, 1'b1);
        send_item(nsvb_pkg::CMD_ERASE, 31'd77, 16'sd0, 1'b0);
        send_item(nsvb_pkg::CMD_ERASE, 31'd77, 16'sd0, 1'b0);
        send_item(nsvb_pkg::CMD_ERASE, 31'd77, 16'sd0, 1'b0);
        send_item(nsvb_pkg::CMD_MAX, 31'd0, 16'sd0, 1'b1);
    endtask

    task automatic test_full_bucket();
        while (ent_count < CAP)
            send_vector(nsvb_pkg::CMD_INSERT, 31'($urandom()), 1);
        send_vector(nsvb_pkg::CMD_INSERT, 31'd999, 2);
        send_item(nsvb_pkg::CMD_MAX, 31'd0, 16'sd0, 1'b0);
        send_vector(nsvb_pkg::CMD_SCORE, 31'd0, 2);
        while (ent_count > CAP - 4)
            send_item(nsvb_pkg::CMD_ERASE, ent_id[$urandom_range(0, ent_count - 1)],
                      rand_elem(), 1'b0);
    endtask

    task automatic test_random_traffic();
        int sent;
        int r;
        sent = 0;
        while (sent < 40)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            r = $urandom_range(0, 9);
            if (r < 4)
            begin
                send_vector(nsvb_pkg::CMD_INSERT, 31'($urandom()), $urandom_range(1, 5));
                sent += 3;
            end
            else if (r < 6)
            begin
                send_vector(nsvb_pkg::CMD_SCORE, 31'($urandom()), $urandom_range(1, 5));
                sent += 3;
            end
            else if (r < 8)
            begin
                if (ent_count > 0 && $urandom_range(0, 4) != 0)
                    send_item(nsvb_pkg::CMD_ERASE, ent_id[$urandom_range(0, ent_count - 1)],
                              rand_elem(), 1'($urandom_range(0, 1)));
                else
                    send_item(nsvb_pkg::CMD_ERASE, 31'($urandom()), rand_elem(),
                              1'($urandom_range(0, 1)));
                sent++;
            end
            else
            begin
                send_item(nsvb_pkg::CMD_MAX, 31'($urandom()), rand_elem(),
                          1'($urandom_range(0, 1)));
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd = nsvb_pkg::CMD_INSERT;
        item_id = '0;
        element_value = '0;
        last_element = 1'b0;
        mismatches = 0;
        cycles = 0;
        ent_count = 0;
        vec_fill = 0;
        idle_on = 1'b1;
        for (int i = 0; i < DIM; i++)
            vec_buf[i] = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_bucket();
        test_extreme_vectors();
        test_equal_and_duplicate();
        test_full_bucket();
        test_random_traffic();

        wait_drained();
        repeat (200) @(negedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: sim.f
rtl/nsvb_pkg.sv
rtl/nsvb_div.sv
rtl/norm_sorted_vector_bucket_core.sv
dv/tb_top.sv
